[design/altok_pkg.sv]
// Package for the assembly line tokenizer: token kinds, character codes
// and the control bundle shared by the buffer cells. No dependencies.
`default_nettype none

package altok_pkg;

  // Token kind, also used as the phase of the line scanner.
  typedef enum logic [1:0] {
    KIND_LABEL   = 2'd0,
    KIND_OPCODE  = 2'd1,
    KIND_OPERAND = 2'd2,
    KIND_COMMENT = 2'd3
  } kind_e;

  // Characters with a meaning to the scanner.
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_SEMI  = 8'h3B;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_COMMA = 8'h2C;

  // Control common to every buffer cell in a cycle.
  typedef struct packed {
    logic       shift;
    logic [7:0] data;
  } cell_ctrl_t;

endpackage

`default_nettype wire

[design/altok_if.sv]
// Handshake interfaces for the tokenizer: the character request channel
// and the token character channel. No dependencies.
`default_nettype none

interface altok_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] ch;
  logic       end_of_text;

  modport source (output valid, ch, end_of_text, input ready);
  modport sink   (input valid, ch, end_of_text, output ready);
endinterface

interface altok_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_char;
  logic [1:0] token_kind;
  logic       token_end;
  logic       truncated;

  modport source (output valid, out_char, token_kind, token_end, truncated, input ready);
  modport sink   (input valid, out_char, token_kind, token_end, truncated, output ready);
endinterface

`default_nettype wire

[design/altok_cell.sv]
// One byte cell of the token buffer chain. It is written in place when the
// scanner stores a character and shifts toward cell zero while emitting.
// Depends on altok_pkg.
`default_nettype none

module altok_cell (
  input  wire logic                   clk_i,
  input  wire altok_pkg::cell_ctrl_t  ctrl_i,
  input  wire logic                   load_i,
  input  wire logic [7:0]             next_i,
  output logic [7:0]                  data_o
);
  import altok_pkg::*;

  logic [7:0] data_q, data_d;

  // Shift wins; stores never happen during an emission.
  always_comb begin
    data_d = data_q;
    if (ctrl_i.shift) begin
      data_d = next_i;
    end else if (load_i) begin
      data_d = ctrl_i.data;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;

endmodule

`default_nettype wire

[design/assembly_line_tokenizer.sv]
// Assembly line tokenizer top level: line scanner control and the chain of
// buffer cells. Depends on altok_pkg, altok_if and altok_cell.
//
// Usage: source characters arrive on in_i, one request per character, with
// end_of_text set on the last one of a text. A character is taken whenever
// no token is being delivered. When a character ends a non-empty token, the
// token leaves on out_o one character per request, starting in the cycle
// after the ending character, tagged with its kind, with token_end on its
// final character and truncated set on all of them if the buffer overflowed.
// A token keeps in_i.ready low until its final character has been taken.
// The buffer is a row of MAX_TOKEN_LEN byte cells; characters are written in
// place and the row shifts one cell toward the output per delivered request.
// When the receiver stalls, the current character is held and the row stops.
// Reset clears the phase, the literal flag, the length and the overflow flag
// and leaves no emission pending. end_of_text discards the unfinished token
// after the character has been handled as usual.
`default_nettype none

module assembly_line_tokenizer #(
  parameter int MAX_TOKEN_LEN = 32
) (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  altok_in_if.sink    in_i,
  altok_out_if.source out_o
);
  import altok_pkg::*;

  localparam int LW = $clog2(MAX_TOKEN_LEN + 1);

  kind_e          phase_q, phase_d;
  logic           lit_q, lit_d;
  logic [LW-1:0]  len_q, len_d;
  logic           ovf_q, ovf_d;
  logic [LW-1:0]  rem_q, rem_d;
  kind_e          kind_q, kind_d;
  logic           trunc_q, trunc_d;

  logic           in_fire, out_fire;
  logic           store, emit;
  kind_e          emit_kind;
  logic [7:0]     ch;
  logic           is_sep;
  cell_ctrl_t     ctrl;
  logic [7:0]     cell_data [MAX_TOKEN_LEN];

  assign ch       = in_i.ch;
  assign in_i.ready = (rem_q == '0);
  assign in_fire  = in_i.valid && in_i.ready;
  assign out_fire = out_o.valid && out_o.ready;
  assign is_sep   = (ch == CH_SEMI) || (ch == CH_COLON) || (ch == CH_SPACE) ||
                    (ch == CH_TAB) || (ch == CH_COMMA);

  // Character classification and next scanner state.
  always_comb begin
    phase_d   = phase_q;
    lit_d     = lit_q;
    len_d     = len_q;
    ovf_d     = ovf_q;
    rem_d     = rem_q;
    kind_d    = kind_q;
    trunc_d   = trunc_q;
    store     = 1'b0;
    emit      = 1'b0;
    emit_kind = KIND_OPCODE;

    if (out_fire) begin
      rem_d = rem_q - LW'(1);
    end

    if (in_fire) begin
      if (ch == CH_QUOTE) begin
        lit_d = !lit_q;
        store = 1'b1;
      end else if (ch == CH_CR) begin
        // Carriage returns are ignored.
      end else if (ch == CH_LF) begin
        lit_d   = 1'b0;
        emit    = 1'b1;
        emit_kind = (phase_q == KIND_LABEL || phase_q == KIND_OPCODE) ?
                    KIND_OPCODE : phase_q;
        phase_d = KIND_LABEL;
      end else if (is_sep && lit_q) begin
        store = 1'b1;
      end else if (ch == CH_SEMI) begin
        phase_d = KIND_COMMENT;
      end else if (ch == CH_COLON) begin
        if (phase_q == KIND_LABEL) begin
          emit      = 1'b1;
          emit_kind = KIND_LABEL;
          phase_d   = KIND_OPCODE;
        end
      end else if (ch == CH_SPACE || ch == CH_TAB) begin
        if (len_q != '0 && (phase_q == KIND_LABEL || phase_q == KIND_OPCODE)) begin
          emit      = 1'b1;
          emit_kind = KIND_OPCODE;
          phase_d   = KIND_OPERAND;
        end
      end else if (ch == CH_COMMA) begin
        if (phase_q == KIND_OPERAND) begin
          emit      = 1'b1;
          emit_kind = KIND_OPERAND;
        end
      end else begin
        store = 1'b1;
      end

      // Store into the next free cell or mark the token as truncated.
      if (store) begin
        if (len_q < LW'(MAX_TOKEN_LEN)) begin
          len_d = len_q + LW'(1);
        end else begin
          ovf_d = 1'b1;
        end
      end

      // Hand a finished token to the output side.
      if (emit) begin
        if (len_q != '0) begin
          rem_d   = len_q;
          kind_d  = emit_kind;
          trunc_d = ovf_q;
        end
        len_d = '0;
        ovf_d = 1'b0;
      end

      // End of text drops the unfinished token and restarts the scanner.
      if (in_i.end_of_text) begin
        phase_d = KIND_LABEL;
        lit_d   = 1'b0;
        len_d   = '0;
        ovf_d   = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= KIND_LABEL;
      lit_q   <= 1'b0;
      len_q   <= '0;
      ovf_q   <= 1'b0;
      rem_q   <= '0;
      kind_q  <= KIND_LABEL;
      trunc_q <= 1'b0;
    end else begin
      phase_q <= phase_d;
      lit_q   <= lit_d;
      len_q   <= len_d;
      ovf_q   <= ovf_d;
      rem_q   <= rem_d;
      kind_q  <= kind_d;
      trunc_q <= trunc_d;
    end
  end

  // Chain of buffer cells; cell zero feeds the output.
  assign ctrl.shift = out_fire;
  assign ctrl.data  = ch;

  for (genvar i = 0; i < MAX_TOKEN_LEN; i++) begin : g_cell
    logic [7:0] next_data;
    logic       load;
    if (i == MAX_TOKEN_LEN - 1) begin : g_tail
      assign next_data = 8'h00;
    end else begin : g_mid
      assign next_data = cell_data[i+1];
    end
    assign load = store && (len_q == LW'(i));
    altok_cell u_cell (
      .clk_i  (clk_i),
      .ctrl_i (ctrl),
      .load_i (load),
      .next_i (next_data),
      .data_o (cell_data[i])
    );
  end

  // Output channel.
  assign out_o.valid      = (rem_q != '0);
  assign out_o.out_char   = cell_data[0];
  assign out_o.token_kind = kind_q;
  assign out_o.token_end  = (rem_q == LW'(1));
  assign out_o.truncated  = trunc_q;

endmodule

`default_nettype wire

[design/altok_checker.sv]
// Port-level checks for the tokenizer and the bind that attaches them.
// Depends on altok_if through the top level's interface ports.
`default_nettype none

module altok_checker (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       in_ready,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [7:0] out_char,
  input wire logic [1:0] token_kind,
  input wire logic       token_end,
  input wire logic       truncated
);

  // No character request is taken while a token is being delivered.
  a_no_input_during_burst: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> !in_ready)
    else $error("input accepted while a token was being delivered");

  // A token keeps going until its final character has been taken.
  a_burst_continues: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid && out_ready && !token_end) |=> out_valid)
    else $error("token burst ended before its final character");

  // Kind and truncation flag are the same on every character of a token.
  a_token_tags_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid && out_ready && !token_end) |=> ($stable(token_kind) && $stable(truncated)))
    else $error("token tags changed within a token");

  // A stalled request stays valid and holds its character and its token_end flag.
  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_char) && $stable(token_end)))
    else $error("stalled token character changed");

endmodule

bind assembly_line_tokenizer altok_checker u_altok_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_ready   (in_i.ready),
  .out_valid  (out_o.valid),
  .out_ready  (out_o.ready),
  .out_char   (out_o.out_char),
  .token_kind (out_o.token_kind),
  .token_end  (out_o.token_end),
  .truncated  (out_o.truncated)
);

`default_nettype wire

[bench/tb_assembly_line_tokenizer.sv]
// Self-checking bench for the assembly line tokenizer: directed and random
// source text, random idling on both channels, token characters checked in order.
// Depends on altok_pkg, altok_if and assembly_line_tokenizer.

module tb_assembly_line_tokenizer;
  import altok_pkg::*;

  localparam int          TOK_MAX    = 32;
  localparam int          RAND_ITEMS = 320;
  localparam int          TAIL_WAIT  = 48;
  localparam int unsigned CYCLE_CAP  = 400000;
  localparam string       WORD_CHARS = "abcdefghijklmnopqrstuvwxyz0123456789_.$#@";

  // One source character request and one expected token character.
  typedef struct {
    logic [7:0] ch;
    bit         eot;
    bit         drain;
  } src_char_t;

  typedef struct {
    logic [7:0] out_char;
    kind_e      kind;
    logic       tend;
    logic       trunc;
  } token_char_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  altok_in_if  in_if ();
  altok_out_if out_if ();

  assembly_line_tokenizer #(
    .MAX_TOKEN_LEN(TOK_MAX)
  ) u_top (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if),
    .out_o (out_if)
  );

  src_char_t   pending_chars[$];
  token_char_t expected_chars[$];

  // Mirror of the scanner state.
  kind_e      scan_phase;
  logic       quoted;
  logic [7:0] held_bytes[TOK_MAX];
  int         held_len;
  logic       held_ovf;

  int unsigned mismatch_count;
  logic [31:0] cycle_cnt;
  int unsigned send_gap;
  int unsigned ready_hold;

  // Clock generation.
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Idle length for either side; there is no idling while bits 9:8 of the cycle counter are zero.
  function automatic int unsigned idle_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (cycle_cnt[9:8] == 2'd0) return 0;
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Store a byte in the token buffer, or flag the overflow when it is full.
  function automatic void keep_byte(input logic [7:0] c);
    if (held_len < TOK_MAX) begin
      held_bytes[held_len] = c;
      held_len++;
    end else begin
      held_ovf = 1'b1;
    end
  endfunction

  // Queue the held token as expected characters and empty the buffer.
  function automatic void queue_token(input kind_e kind);
    token_char_t t;
    for (int i = 0; i < held_len; i++) begin
      t.out_char = held_bytes[i];
      t.kind     = kind;
      t.tend     = (i == held_len - 1);
      t.trunc    = held_ovf;
      expected_chars.push_back(t);
    end
    held_len = 0;
    held_ovf = 1'b0;
  endfunction

  // Clear the scanner state, as at reset and after the end of a text.
  function automatic void clear_scan();
    scan_phase = KIND_LABEL;
    quoted     = 1'b0;
    held_len   = 0;
    held_ovf   = 1'b0;
  endfunction

  // Advance the mirrored scanner by one accepted character.
  function automatic void scan_char(input logic [7:0] c, input logic eot);
    bit sep;
    sep = (c == CH_SEMI) || (c == CH_COLON) || (c == CH_SPACE) || (c == CH_TAB) ||
          (c == CH_COMMA);
    if (c == CH_QUOTE) begin
      quoted = !quoted;
      keep_byte(c);
    end else if (c == CH_CR) begin
      // Carriage returns leave everything as it is.
    end else if (c == CH_LF) begin
      quoted = 1'b0;
      queue_token((scan_phase == KIND_LABEL || scan_phase == KIND_OPCODE) ?
                  KIND_OPCODE : scan_phase);
      scan_phase = KIND_LABEL;
    end else if (sep && quoted) begin
      keep_byte(c);
    end else if (c == CH_SEMI) begin
      scan_phase = KIND_COMMENT;
    end else if (c == CH_COLON) begin
      if (scan_phase == KIND_LABEL) begin
        queue_token(KIND_LABEL);
        scan_phase = KIND_OPCODE;
      end
    end else if (c == CH_SPACE || c == CH_TAB) begin
      if (held_len != 0 && (scan_phase == KIND_LABEL || scan_phase == KIND_OPCODE)) begin
        queue_token(KIND_OPCODE);
        scan_phase = KIND_OPERAND;
      end
    end else if (c == CH_COMMA) begin
      if (scan_phase == KIND_OPERAND) begin
        queue_token(KIND_OPERAND);
      end
    end else begin
      keep_byte(c);
    end
    if (eot) begin
      clear_scan();
    end
  endfunction

  // Stimulus builders.
  task automatic push_char(input logic [7:0] c, input bit eot = 1'b0);
    src_char_t s;
    s.ch    = c;
    s.eot   = eot;
    s.drain = 1'b0;
    pending_chars.push_back(s);
  endtask

  task automatic push_str(input string s, input bit eot = 1'b0);
    for (int i = 0; i < s.len(); i++) begin
      push_char(s[i], eot && (i == s.len() - 1));
    end
  endtask

  task automatic push_word(input int n);
    for (int i = 0; i < n; i++) begin
      push_char(WORD_CHARS[$urandom_range(0, WORD_CHARS.len() - 1)]);
    end
  endtask

  task automatic push_blank();
    int n;
    n = $urandom_range(1, 2);
    repeat (n) push_char($urandom_range(0, 1) ? CH_SPACE : CH_TAB);
  endtask

  // Quoted literal whose body may hold any separator but a newline or a quote.
  task automatic push_literal();
    int          n;
    logic [7:0]  c;
    n = $urandom_range(0, 5);
    push_char(CH_QUOTE);
    repeat (n) begin
      case ($urandom_range(0, 6))
        0: c = CH_SEMI;
        1: c = CH_COLON;
        2: c = CH_SPACE;
        3: c = CH_TAB;
        4: c = CH_COMMA;
        default: c = WORD_CHARS[$urandom_range(0, WORD_CHARS.len() - 1)];
      endcase
      push_char(c);
    end
    push_char(CH_QUOTE);
  endtask

  // A well-formed line: optional label, opcode, operands, optional comment.
  task automatic push_line();
    int nops;
    int nc;
    if ($urandom_range(0, 1)) begin
      push_word($urandom_range(1, 6));
      push_char(CH_COLON);
    end
    push_blank();
    push_word($urandom_range(1, 5));
    nops = $urandom_range(0, 3);
    for (int i = 0; i < nops; i++) begin
      if (i != 0) push_char(CH_COMMA);
      if (i == 0 || $urandom_range(0, 2) == 0) push_blank();
      if ($urandom_range(0, 3) == 0) push_literal();
      else push_word($urandom_range(1, 6));
    end
    if ($urandom_range(0, 3) == 0) begin
      push_char(CH_SEMI);
      nc = $urandom_range(1, 8);
      repeat (nc) begin
        case ($urandom_range(0, 5))
          0: push_char(CH_SPACE);
          1: push_char(CH_COMMA);
          2: push_char(CH_COLON);
          default: push_word(1);
        endcase
      end
    end
    if ($urandom_range(0, 4) == 0) push_char(CH_CR);
    push_char(CH_LF);
  endtask

  // A line with one token around the buffer size, in one of three phases.
  task automatic push_long_line();
    int n;
    case ($urandom_range(0, 4))
      0: n = TOK_MAX - 1;
      1: n = TOK_MAX;
      2: n = TOK_MAX + 1;
      3: n = TOK_MAX + 2;
      default: n = TOK_MAX + 13;
    endcase
    case ($urandom_range(0, 2))
      0: begin
        push_word(n);
        push_char(CH_COLON);
      end
      1: begin
        push_blank();
        push_word(2);
        push_blank();
        push_word(n);
      end
      default: begin
        push_char(CH_SEMI);
        push_word(n);
      end
    endcase
    push_char(CH_LF);
  endtask

  // Cycle counter and watchdog.
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_CAP) begin
      $display("[assembly_line_tokenizer] ERROR");
      $finish;
    end
  end

  // Request driver: feeds the pending characters with random gaps.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_if.valid       <= 1'b0;
      in_if.ch          <= 8'h00;
      in_if.end_of_text <= 1'b0;
      send_gap          <= 0;
    end else if (!in_if.valid || in_if.ready) begin
      if (send_gap != 0) begin
        in_if.valid <= 1'b0;
        send_gap    <= send_gap - 1;
      end else if (pending_chars.size() != 0 &&
                   (!pending_chars[0].drain ||
                    (!in_if.valid && expected_chars.size() == 0))) begin
        in_if.valid       <= 1'b1;
        in_if.ch          <= pending_chars[0].ch;
        in_if.end_of_text <= pending_chars[0].eot;
        pending_chars.pop_front();
        send_gap          <= idle_len();
      end else begin
        in_if.valid <= 1'b0;
      end
    end
  end

  // Receiver: random stalls on the token character channel.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
      ready_hold   <= 0;
    end else if (ready_hold != 0) begin
      out_if.ready <= 1'b0;
      ready_hold   <= ready_hold - 1;
    end else begin
      out_if.ready <= 1'b1;
      ready_hold   <= idle_len();
    end
  end

  // Monitor: checks delivered token characters, then predicts from accepted input.
  always @(posedge clk_i) begin : monitor
    token_char_t want;
    if (rst_ni) begin
      if (out_if.valid && out_if.ready) begin
        if (expected_chars.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10) begin
            $display("unexpected token character %h kind %0d end %b trunc %b",
                     out_if.out_char, out_if.token_kind, out_if.token_end,
                     out_if.truncated);
          end
        end else begin
          want = expected_chars.pop_front();
          if (out_if.out_char !== want.out_char || out_if.token_kind !== want.kind ||
              out_if.token_end !== want.tend || out_if.truncated !== want.trunc) begin
            mismatch_count++;
            if (mismatch_count <= 10) begin
              $display("token character mismatch: expected %h/%0d/%b/%b, got %h/%0d/%b/%b",
                       want.out_char, want.kind, want.tend, want.trunc,
                       out_if.out_char, out_if.token_kind, out_if.token_end,
                       out_if.truncated);
            end
          end
        end
      end
      if (in_if.valid && in_if.ready) begin
        scan_char(in_if.ch, in_if.end_of_text);
      end
    end
  end

  initial begin
    int directed_n;
    int r;
    in_if.valid       = 1'b0;
    in_if.ch          = 8'h00;
    in_if.end_of_text = 1'b0;
    out_if.ready      = 1'b0;
    cycle_cnt         = '0;
    mismatch_count    = 0;
    clear_scan();

    // Directed text: label, stray colon and tab, comma outside the operand
    // phase, extreme bytes as an operand, quoted separators, a carriage
    // return, a comment, a label-phase newline and a text ending mid-token.
    push_str("L:");
    push_char(CH_COLON);
    push_char(CH_TAB);
    push_str("mv,");
    push_char(CH_SPACE);
    push_char(8'h00);
    push_char(8'hFF);
    push_char(CH_COMMA);
    push_char(CH_QUOTE);
    push_char(CH_SEMI);
    push_char(CH_COLON);
    push_char(CH_TAB);
    push_char(CH_COMMA);
    push_char(CH_SPACE);
    push_char(CH_QUOTE);
    push_char(CH_CR);
    push_char(CH_SEMI);
    push_str("c");
    push_char(CH_LF);
    push_str("q");
    push_char(CH_LF);
    push_str("x", 1'b1);
    directed_n = pending_chars.size();

    // Random text: mostly well-formed lines, some noise and oversized tokens.
    while (pending_chars.size() < directed_n + RAND_ITEMS) begin
      r = $urandom_range(0, 99);
      if (r < 12) begin
        repeat ($urandom_range(1, 10)) push_char(8'($urandom_range(0, 255)));
      end else if (r < 18) begin
        push_long_line();
      end else begin
        push_line();
      end
      if ($urandom_range(0, 11) == 0) pending_chars[$].eot = 1'b1;
    end
    // Hold the sender twice until all token characters have drained.
    pending_chars[pending_chars.size() / 3].drain       = 1'b1;
    pending_chars[(pending_chars.size() * 2) / 3].drain = 1'b1;

    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    while (pending_chars.size() != 0 || in_if.valid) @(posedge clk_i);
    while (expected_chars.size() != 0) @(posedge clk_i);
    repeat (TAIL_WAIT) @(posedge clk_i);

    if (mismatch_count == 0 && expected_chars.size() == 0) begin
      $display("[assembly_line_tokenizer] OK");
    end else begin
      $display("[assembly_line_tokenizer] ERROR");
    end
    $finish;
  end

endmodule
